// ----- design/pwns_pkg.sv -----
package pwns_pkg;

  localparam int MAX_REFS   = 4096;
  localparam int IDX_W      = $clog2(MAX_REFS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int NAX        = 3;
  localparam int POS_W      = 24;
  localparam int DIR_W      = 16;
  localparam int REF_W      = NAX * (POS_W + DIR_W);
  localparam int OPC_W      = 2;
  localparam int OUT_DATA_W = 16;

  // remainder by 2.0 keeps the low bits of the magnitude
  localparam int DD_W       = DIR_W - 1;
  localparam int SP_W       = 2 * POS_W;
  localparam int SD_W       = 2 * DD_W;

  // square root unit: 2*SQ_N bit radicand, SQ_N bit root
  localparam int SQ_N       = 26;
  localparam int SQ_X_W     = 2 * SQ_N;
  localparam int SQ_R_W     = SQ_N + 2;

  localparam int P_W        = SQ_N;
  localparam int O_W        = 16;
  localparam int FRAC_O     = 14;
  localparam int R_W        = P_W + FRAC_O;
  localparam int DIV_STEPS  = R_W;
  localparam int SUM_W      = R_W + IDX_W;
  localparam int MEAN_STEPS = SUM_W;
  localparam int MEAN_W     = R_W;
  localparam int MEAN_SHIFT = 8;
  localparam int ALPHA_W    = 24;
  localparam int PROD_W     = ALPHA_W + O_W;
  localparam int D_W        = R_W + 1;
  localparam int IT_W       = $clog2(MEAN_STEPS);

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [SQ_X_W-1:0] x;
    logic [SQ_R_W-1:0] rem;
    logic [SQ_N-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic             v;
    logic             first;
    logic [IDX_W-1:0] idx;
  } issue_t;

  typedef struct packed {
    logic             v;
    logic             first;
    logic [IDX_W-1:0] idx;
    logic [P_W-1:0]   p;
    logic [O_W-1:0]   o;
  } dist_t;

  typedef struct packed {
    logic           v;
    logic [R_W-1:0] r;
  } ratio_t;

  // one digit of a restoring square root
  function automatic sq_t isqrt_step(sq_t s);
    logic [SQ_R_W+1:0] t;
    logic [SQ_R_W+1:0] trial;
    sq_t               n;
    t     = {s.rem, s.x[SQ_X_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.x   = {s.x[SQ_X_W-3:0], 2'b00};
    if (t >= trial) begin
      n.rem  = SQ_R_W'(t - trial);
      n.root = {s.root[SQ_N-2:0], 1'b1};
    end else begin
      n.rem  = t[SQ_R_W-1:0];
      n.root = {s.root[SQ_N-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ----- design/pwns_ram.sv -----
module pwns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pwns_dist_pipe.sv -----
module pwns_dist_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pwns_pkg::issue_t            iss_i,
  input  logic [pwns_pkg::REF_W-1:0]  ref_i,
  input  logic [pwns_pkg::REF_W-1:0]  qry_i,
  output pwns_pkg::dist_t             dist_o,
  output pwns_pkg::ratio_t            ratio_o
);
  import pwns_pkg::*;

  // stage 1: absolute differences
  logic [POS_W:0]   dp   [NAX];
  logic [POS_W:0]   dpa  [NAX];
  logic [DIR_W:0]   dd   [NAX];
  logic [DIR_W:0]   dda  [NAX];
  logic [POS_W-1:0] ap_q [NAX];
  logic [DD_W-1:0]  ad_q [NAX];
  logic             v1_q, f1_q;
  logic [IDX_W-1:0] i1_q;

  // stage 2: squares
  logic [SP_W-1:0]  sp_q [NAX];
  logic [SD_W-1:0]  sd_q [NAX];
  logic             v2_q, f2_q;
  logic [IDX_W-1:0] i2_q;

  // square root stages, entry 0 holds the sums
  logic             sv_q [SQ_N+1];
  logic             sf_q [SQ_N+1];
  logic [IDX_W-1:0] si_q [SQ_N+1];
  sq_t              sqp_q [SQ_N+1];
  sq_t              sqo_q [SQ_N+1];

  // divider stages
  logic             dvv_q [DIV_STEPS+1];
  logic [O_W-1:0]   dvr_q [DIV_STEPS+1];
  logic [R_W-1:0]   dvq_q [DIV_STEPS+1];
  logic [O_W-1:0]   dvs_q [DIV_STEPS+1];
  logic [O_W:0]     dvt   [DIV_STEPS];
  logic             dvge  [DIV_STEPS];

  logic [SP_W+1:0]  psum;
  logic [SD_W+1:0]  osum;

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      dp[k]  = {ref_i[k*POS_W+POS_W-1], ref_i[k*POS_W +: POS_W]}
             - {qry_i[k*POS_W+POS_W-1], qry_i[k*POS_W +: POS_W]};
      dpa[k] = dp[k][POS_W] ? (~dp[k] + 1'b1) : dp[k];
      dd[k]  = {ref_i[NAX*POS_W+k*DIR_W+DIR_W-1], ref_i[NAX*POS_W+k*DIR_W +: DIR_W]}
             - {qry_i[NAX*POS_W+k*DIR_W+DIR_W-1], qry_i[NAX*POS_W+k*DIR_W +: DIR_W]};
      dda[k] = dd[k][DIR_W] ? (~dd[k] + 1'b1) : dd[k];
    end
    psum = (SP_W+2)'(sp_q[0]) + (SP_W+2)'(sp_q[1]) + (SP_W+2)'(sp_q[2]);
    osum = (SD_W+2)'(sd_q[0]) + (SD_W+2)'(sd_q[1]) + (SD_W+2)'(sd_q[2]);
    for (int k = 0; k < DIV_STEPS; k++) begin
      dvt[k]  = {dvr_q[k], dvq_q[k][R_W-1]};
      dvge[k] = dvt[k] >= {1'b0, dvs_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int k = 0; k <= SQ_N; k++) sv_q[k] <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dvv_q[k] <= 1'b0;
    end else begin
      v1_q    <= iss_i.v;
      v2_q    <= v1_q;
      sv_q[0] <= v2_q;
      for (int k = 0; k < SQ_N; k++) sv_q[k+1] <= sv_q[k];
      // only first-pass entries need the ratio
      dvv_q[0] <= sv_q[SQ_N] && sf_q[SQ_N];
      for (int k = 0; k < DIV_STEPS; k++) dvv_q[k+1] <= dvv_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q <= iss_i.first;
    i1_q <= iss_i.idx;
    for (int k = 0; k < NAX; k++) begin
      ap_q[k] <= dpa[k][POS_W-1:0];
      ad_q[k] <= dda[k][DD_W-1:0];
    end
    f2_q <= f1_q;
    i2_q <= i1_q;
    for (int k = 0; k < NAX; k++) begin
      sp_q[k] <= ap_q[k] * ap_q[k];
      sd_q[k] <= ad_q[k] * ad_q[k];
    end
    sf_q[0]       <= f2_q;
    si_q[0]       <= i2_q;
    sqp_q[0].x    <= SQ_X_W'(psum);
    sqp_q[0].rem  <= '0;
    sqp_q[0].root <= '0;
    sqo_q[0].x    <= SQ_X_W'(osum);
    sqo_q[0].rem  <= '0;
    sqo_q[0].root <= '0;
    for (int k = 0; k < SQ_N; k++) begin
      sf_q[k+1]  <= sf_q[k];
      si_q[k+1]  <= si_q[k];
      sqp_q[k+1] <= isqrt_step(sqp_q[k]);
      sqo_q[k+1] <= isqrt_step(sqo_q[k]);
    end
    // a zero divisor gives all ones, the saturated ratio
    dvr_q[0] <= '0;
    dvq_q[0] <= {sqp_q[SQ_N].root, {FRAC_O{1'b0}}};
    dvs_q[0] <= sqo_q[SQ_N].root[O_W-1:0];
    for (int k = 0; k < DIV_STEPS; k++) begin
      dvr_q[k+1] <= dvge[k] ? O_W'(dvt[k] - {1'b0, dvs_q[k]}) : dvt[k][O_W-1:0];
      dvq_q[k+1] <= {dvq_q[k][R_W-2:0], dvge[k]};
      dvs_q[k+1] <= dvs_q[k];
    end
  end

  assign dist_o.v     = sv_q[SQ_N];
  assign dist_o.first = sf_q[SQ_N];
  assign dist_o.idx   = si_q[SQ_N];
  assign dist_o.p     = sqp_q[SQ_N].root;
  assign dist_o.o     = sqo_q[SQ_N].root[O_W-1:0];
  assign ratio_o.v    = dvv_q[DIV_STEPS];
  assign ratio_o.r    = dvq_q[DIV_STEPS];

endmodule

// ----- design/pose_weighted_nearest_search_top.sv -----
// channel  dir  tvalid/tready            payload
// s_axis   in   s_axis_tvalid_i/_tready_o tdata: pos_x,pos_y,pos_z,dir_x,dir_y,dir_z; tuser: opcode
// m_axis   out  m_axis_tvalid_o/_tready_i tdata: nearest_index (zero padded); tuser: found
//
// a query on an empty store goes straight to the done state, skipping both passes
// a query makes two passes over the N stored points: the single read port of the
// reference memory streams one entry per cycle in each of the two passes
// reset empties the store (count to zero); memory contents are left as they are
// no input transaction is taken while a query runs; the result waits in the output
// register, and a query that finishes while it is still occupied holds until it drains
module pose_weighted_nearest_search_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], dir_x[87:72], dir_y[103:88], dir_z[119:104]
  input  logic [pwns_pkg::REF_W-1:0]      s_axis_tdata_i,
  // opcode[1:0]
  input  logic [pwns_pkg::OPC_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // nearest_index[11:0], zeros above
  output logic [pwns_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // found[0]
  output logic                            m_axis_tuser_o
);
  import pwns_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PASS1 = 6'b000010,
    ST_MEAN  = 6'b000100,
    ST_ROOT  = 6'b001000,
    ST_PASS2 = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;     // points in the store
  logic [CNT_W-1:0]  iss_q, iss_d;     // entries issued in this pass
  logic [CNT_W-1:0]  rcv_q, rcv_d;     // entries retired in this pass
  logic [IT_W-1:0]   it_q, it_d;       // step of the mean divider or root unit

  logic              s_acc;
  opcode_e           opc;
  logic              full;
  logic              issue;
  logic              out_free;
  logic              pass1_end;
  logic              mean_end;
  logic              root_end;

  logic [REF_W-1:0]  qry_q;
  logic [REF_W-1:0]  ref_rd;
  issue_t            iss_pipe_q;
  dist_t             pdist;
  ratio_t            ratio;

  // mean = sum / count, one quotient bit a cycle
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  mrem_q;
  logic [SUM_W-1:0]  mqd_q;
  logic [CNT_W:0]    mt;
  logic              mge;
  logic [SUM_W-1:0]  mqd_nx;

  // alpha = sqrt(mean << 8), one root bit a cycle
  sq_t               sq_q;
  sq_t               sq_nx;
  logic [ALPHA_W-1:0] alpha_q;

  // second pass: cost and running minimum
  logic              mul_v_q;
  logic [IDX_W-1:0]  mul_idx_q;
  logic [P_W-1:0]    mul_p_q;
  logic [PROD_W-1:0] mul_prod_q;
  logic              cost_v_q;
  logic [IDX_W-1:0]  cost_idx_q;
  logic [D_W-1:0]    cost_q;
  logic              have_q;
  logic [D_W-1:0]    best_q;
  logic [IDX_W-1:0]  best_idx_q;

  logic              m_valid_q;
  logic [IDX_W-1:0]  m_idx_q;
  logic              m_found_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign opc       = opcode_e'(s_axis_tuser_i);
  assign full      = (cnt_q >= CNT_W'(MAX_REFS));
  assign issue     = ((state_q == ST_PASS1) || (state_q == ST_PASS2)) && (iss_q < cnt_q);
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign pass1_end = (state_q == ST_PASS1) && (rcv_q == cnt_q);
  assign mean_end  = (state_q == ST_MEAN) && (it_q == IT_W'(MEAN_STEPS - 1));
  assign root_end  = (state_q == ST_ROOT) && (it_q == IT_W'(SQ_N - 1));

  assign mt     = {mrem_q, mqd_q[SUM_W-1]};
  assign mge    = mt >= {1'b0, cnt_q};
  assign mqd_nx = {mqd_q[SUM_W-2:0], mge};
  assign sq_nx  = isqrt_step(sq_q);

  pwns_ram #(
    .WIDTH(REF_W),
    .DEPTH(MAX_REFS)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (s_acc && (opc == OP_APPEND) && !full),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (iss_q[IDX_W-1:0]),
    .rdata_o (ref_rd)
  );

  pwns_dist_pipe u_dist_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .iss_i   (iss_pipe_q),
    .ref_i   (ref_rd),
    .qry_i   (qry_q),
    .dist_o  (pdist),
    .ratio_o (ratio)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    iss_d   = iss_q;
    rcv_d   = rcv_q;
    it_d    = it_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (opc)
            OP_CLEAR: cnt_d = '0;
            OP_APPEND: begin
              if (!full) cnt_d = cnt_q + 1'b1;
            end
            OP_QUERY: begin
              iss_d   = '0;
              rcv_d   = '0;
              state_d = (cnt_q == '0) ? ST_DONE : ST_PASS1;
            end
            default: ;
          endcase
        end
      end
      ST_PASS1: begin
        if (issue) iss_d = iss_q + 1'b1;
        if (ratio.v) rcv_d = rcv_q + 1'b1;
        if (pass1_end) begin
          state_d = ST_MEAN;
          it_d    = '0;
        end
      end
      ST_MEAN: begin
        it_d = it_q + 1'b1;
        if (mean_end) begin
          state_d = ST_ROOT;
          it_d    = '0;
        end
      end
      ST_ROOT: begin
        it_d = it_q + 1'b1;
        if (root_end) begin
          state_d = ST_PASS2;
          iss_d   = '0;
          rcv_d   = '0;
        end
      end
      ST_PASS2: begin
        if (issue) iss_d = iss_q + 1'b1;
        if (cost_v_q) rcv_d = rcv_q + 1'b1;
        if (rcv_q == cnt_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      iss_q        <= '0;
      rcv_q        <= '0;
      it_q         <= '0;
      iss_pipe_q   <= '0;
      mul_v_q      <= 1'b0;
      cost_v_q     <= 1'b0;
      have_q       <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      iss_q        <= iss_d;
      rcv_q        <= rcv_d;
      it_q         <= it_d;
      iss_pipe_q.v <= issue;
      // read data arrives in the cycle after the address, so the tag is registered to follow it
      iss_pipe_q.first <= (state_q == ST_PASS1);
      iss_pipe_q.idx   <= iss_q[IDX_W-1:0];
      mul_v_q      <= pdist.v && !pdist.first;
      cost_v_q     <= mul_v_q;
      if (root_end) begin
        have_q <= 1'b0;
      end else if (cost_v_q) begin
        have_q <= 1'b1;
      end
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && (opc == OP_QUERY)) begin
      qry_q <= s_axis_tdata_i;
      sum_q <= '0;
    end else if ((state_q == ST_PASS1) && ratio.v) begin
      sum_q <= sum_q + SUM_W'(ratio.r);
    end

    if (pass1_end) begin
      mrem_q <= '0;
      mqd_q  <= sum_q;
    end else if (state_q == ST_MEAN) begin
      mrem_q <= mge ? CNT_W'(mt - {1'b0, cnt_q}) : mt[CNT_W-1:0];
      mqd_q  <= mqd_nx;
    end

    if (mean_end) begin
      sq_q.x    <= SQ_X_W'({mqd_nx[MEAN_W-1:0], {MEAN_SHIFT{1'b0}}});
      sq_q.rem  <= '0;
      sq_q.root <= '0;
    end else if (state_q == ST_ROOT) begin
      sq_q <= sq_nx;
    end
    if (root_end) begin
      alpha_q <= sq_nx.root[ALPHA_W-1:0];
    end

    // cost = P * 2^14 + alpha * O, product registered before the add
    mul_idx_q  <= pdist.idx;
    mul_p_q    <= pdist.p;
    mul_prod_q <= alpha_q * pdist.o;
    cost_idx_q <= mul_idx_q;
    cost_q     <= D_W'({mul_p_q, {FRAC_O{1'b0}}}) + D_W'(mul_prod_q);

    // strict compare keeps the first index on ties
    if (cost_v_q && (!have_q || (cost_q < best_q))) begin
      best_q     <= cost_q;
      best_idx_q <= cost_idx_q;
    end

    if ((state_q == ST_DONE) && out_free) begin
      m_found_q <= (cnt_q != '0);
      m_idx_q   <= (cnt_q != '0) ? best_idx_q : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(m_idx_q);
  assign m_axis_tuser_o  = m_found_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_REFS))
    else $error("store count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PASS1) || (state_q == ST_PASS2)) |-> (rcv_q <= iss_q))
    else $error("more entries retired than issued");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ratio.v |-> (state_q == ST_PASS1))
    else $error("ratio arrived outside the first pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised without a finished query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_found_q) |-> (m_idx_q == '0))
    else $error("empty store result carries an index");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pwns_pkg::*;

  localparam int     CLK_HALF   = 1;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE_CYC = 400;
  localparam int     ITEM_CNT   = 100;
  localparam longint DIR_MOD     = 32768;
  localparam longint RATIO_SAT   = (64'd1 << 40) - 1;

  // one input transaction as offered on the slave side
  typedef struct {
    opcode_e             op;
    logic [REF_W-1:0]    data;
    bit                  drain;   // hold it back until every result has come
  } pose_item_t;

  typedef struct {
    logic [OUT_DATA_W-1:0] index;
    logic                  found;
  } nearest_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [REF_W-1:0]      s_axis_tdata_i = '0;
  logic [OPC_W-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  pose_weighted_nearest_search_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // shadow copy of the reference store
  longint     store_pos [MAX_REFS][NAX];
  longint     store_dir [MAX_REFS][NAX];
  int         store_cnt = 0;

  pose_item_t pending_items[$];
  nearest_t   nearest_expected[$];
  pose_item_t cur_item;
  int         err_cnt = 0;
  int         result_cnt = 0;
  longint     cycle_cnt = 0;

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // position distance p (Q.8) and direction distance o (Q.14) to entry j
  task automatic pose_dist(input int j, input longint qp[NAX], input longint qd[NAX],
                           output longint unsigned p, output longint unsigned o);
    longint unsigned ps, os;
    longint          dp, dd;
    ps = 0;
    os = 0;
    for (int k = 0; k < NAX; k++) begin
      dp = store_pos[j][k] - qp[k];
      // remainder truncates toward zero, sign follows the dividend
      dd = (store_dir[j][k] - qd[k]) % DIR_MOD;
      ps += dp * dp;
      os += dd * dd;
    end
    p = floor_sqrt(ps);
    o = floor_sqrt(os);
  endtask

  // updates the shadow store and queues the answer a query is due to give
  task automatic nearest_predict(input pose_item_t it);
    longint          qp[NAX], qd[NAX];
    longint unsigned p, o, r, sum, mean, alpha, d, best;
    int              best_idx;
    nearest_t        res;
    for (int k = 0; k < NAX; k++) begin
      qp[k] = longint'($signed(it.data[k*POS_W +: POS_W]));
      qd[k] = longint'($signed(it.data[NAX*POS_W + k*DIR_W +: DIR_W]));
    end
    case (it.op)
      OP_CLEAR: store_cnt = 0;
      OP_APPEND: begin
        // append to a full store is dropped
        if (store_cnt < MAX_REFS) begin
          for (int k = 0; k < NAX; k++) begin
            store_pos[store_cnt][k] = qp[k];
            store_dir[store_cnt][k] = qd[k];
          end
          store_cnt++;
        end
      end
      OP_QUERY: begin
        if (store_cnt == 0) begin
          res.index = '0;
          res.found = 1'b0;
        end else begin
          sum = 0;
          for (int j = 0; j < store_cnt; j++) begin
            pose_dist(j, qp, qd, p, o);
            if (o == 0) sum += RATIO_SAT;
            else begin
              r = (p << 14) / o;
              sum += (r > RATIO_SAT) ? RATIO_SAT : r;
            end
          end
          mean  = sum / longint'(store_cnt);
          alpha = floor_sqrt(mean << 8);
          best = 0;
          best_idx = 0;
          for (int j = 0; j < store_cnt; j++) begin
            pose_dist(j, qp, qd, p, o);
            d = (p << 14) + alpha * o;
            // strict compare keeps the first index on ties
            if (j == 0 || d < best) begin
              best = d;
              best_idx = j;
            end
          end
          res.index = OUT_DATA_W'(best_idx[IDX_W-1:0]);
          res.found = 1'b1;
        end
        nearest_expected = {nearest_expected, res};
      end
      default: ;  // unused opcode is ignored
    endcase
  endtask

  function automatic pose_item_t mk_item(input opcode_e op, input logic [POS_W-1:0] px,
                                         input logic [POS_W-1:0] py,
                                         input logic [POS_W-1:0] pz,
                                         input logic [DIR_W-1:0] dx,
                                         input logic [DIR_W-1:0] dy,
                                         input logic [DIR_W-1:0] dz, input bit drain);
    pose_item_t it;
    it.op    = op;
    it.data  = {dz, dy, dx, pz, py, px};
    it.drain = drain;
    return it;
  endfunction

  function automatic void add_item(input pose_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0:       return POS_W'($urandom);
      1:       return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return POS_W'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  function automatic logic [DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 9))
      0:       return DIR_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return DIR_W'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic pose_item_t rand_item(input opcode_e op);
    return mk_item(op, rand_pos(), rand_pos(), rand_pos(),
                   rand_dir(), rand_dir(), rand_dir(), 1'b0);
  endfunction

  // driver: bursts of transactions separated by random gaps
  int burst_left = 4;
  int gap_left   = 0;
  int settle_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      busy = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        nearest_predict(cur_item);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_items.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_items[0].drain &&
                     (nearest_expected.size() != 0 || settle_cnt < SETTLE_CYC)) begin
          // pause until all results are back and the block has gone quiet
          settle_cnt = (nearest_expected.size() != 0) ? 0 : settle_cnt + 1;
          s_axis_tvalid_i <= 1'b0;
        end else begin
          settle_cnt = 0;
          cur_item = pending_items.pop_front();
          s_axis_tdata_i  <= cur_item.data;
          s_axis_tuser_i  <= cur_item.op;
          s_axis_tvalid_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: one of three stall patterns chosen at random, with one long hold-off
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (!hold_done && result_cnt >= 5) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (cycle_cnt % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    nearest_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_cnt++;
      if (nearest_expected.size() == 0) begin
        $error("unexpected result: nearest_index %0d found %0d",
               m_axis_tdata_o, m_axis_tuser_o);
        err_cnt++;
      end else begin
        want = nearest_expected.pop_front();
        if (m_axis_tdata_o !== want.index) begin
          $error("nearest_index: expected %0d, actual %0d", want.index, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tuser_o !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_axis_tuser_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** pose_weighted_nearest_search_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int n_pts;
    // directed: empty store, extremes, saturation, ties, unused opcode
    add_item(mk_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
    add_item(mk_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b0));
    add_item(mk_item(OP_APPEND, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                     16'sd16384, 16'sd16384, 16'sd16384, 1'b0));
    add_item(mk_item(OP_APPEND, 24'h800000, 24'h800000, 24'h800000,
                     -16'sd16384, -16'sd16384, -16'sd16384, 1'b0));
    add_item(mk_item(OP_APPEND, 24'h000100, 24'hffff00, 0,
                     16'h7fff, 16'h8000, 16'hffff, 1'b0));
    add_item(mk_item(OP_APPEND, 24'h000100, 24'hffff00, 0,
                     16'h7fff, 16'h8000, 16'hffff, 1'b0));
    add_item(mk_item(OP_QUERY, 24'h000100, 24'hffff00, 0,
                     16'h7fff, 16'h8000, 16'hffff, 1'b0));
    add_item(mk_item(OP_QUERY, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                     16'sd16384, 16'sd16384, 16'sd16384, 1'b0));
    add_item(mk_item(OP_QUERY, 24'h800000, 24'h7fffff, 24'h000000,
                     -16'sd16384, 16'sd16384, 0, 1'b0));
    add_item(mk_item(opcode_e'(2'd3), 24'h123456, 0, 0, 0, 0, 0, 1'b0));
    add_item(mk_item(OP_QUERY, 24'h555555, 24'haaaaaa, 24'h0f0f0f,
                     16'h5555, 16'haaaa, 16'h0f0f, 1'b0));
    add_item(mk_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1));
    // random: clear, a short run of appends, then queries; some noise
    while (pending_items.size() < ITEM_CNT) begin
      if ($urandom_range(0, 5) == 0) begin
        add_item(rand_item(opcode_e'($urandom_range(0, 3))));
      end else begin
        add_item(rand_item(OP_CLEAR));
        n_pts = $urandom_range(0, 12);
        for (int j = 0; j < n_pts; j++) add_item(rand_item(OP_APPEND));
        for (int j = $urandom_range(1, 4); j > 0; j--)
          add_item(rand_item(OP_QUERY));
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_items.size() != 0 || s_axis_tvalid_i || nearest_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_cnt == 0 && nearest_expected.size() == 0) begin
      $display("** pose_weighted_nearest_search_top: PASSED **");
    end else begin
      $display("** pose_weighted_nearest_search_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pwns_pkg.sv
design/pwns_ram.sv
design/pwns_dist_pipe.sv
design/pose_weighted_nearest_search_top.sv
verif/tb.sv
